>>> rtl/longest_suffix_match_trie_top_defines.svh
// Assertion macros for the suffix trie checker
`ifndef LONGEST_SUFFIX_MATCH_TRIE_TOP_DEFINES_SVH
`define LONGEST_SUFFIX_MATCH_TRIE_TOP_DEFINES_SVH

// same-cycle implication
`define LSMT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsmt assertion failed");

// next-cycle implication
`define LSMT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsmt assertion failed");

`endif

>>> rtl/lsmt_pkg.sv
// Package: shared types and constants of the suffix trie engine
package lsmt_pkg;

	localparam int DEF_POOL_NODES = 1024;
	localparam int DEF_ALPHABET   = 26;
	localparam int SYM_W          = 5;
	localparam int IDX_W          = 10;
	localparam int LEN_W          = 7;

	localparam logic             OP_INSERT = 1'b0;
	localparam logic             OP_QUERY  = 1'b1;
	localparam logic [LEN_W-1:0] LEN_NONE  = '1;

	typedef struct packed {
		logic             query;
		logic             sym_ok;
		logic [SYM_W-1:0] sym;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] idx;
	} best_t;

	// queue status seen by its neighbours
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage

>>> rtl/longest_suffix_match_trie_top.sv
// Each letter passes back-end states ST_IDLE and ST_EX; a final letter also passes ST_FIN
// unless an insert walk stopped. A new letter is popped only in ST_IDLE, after the node
// memory read then write of the last one. A query result is registered from ST_FIN.
// Reset: asynchronous, active low; then a clearing pass (ST_CLR) over POOL_NODES*ALPHABET
// entries empties the child table; up to three transfers wait in front end and queue.
// Top level: front end, queue and back end of the suffix trie engine
module longest_suffix_match_trie_top import lsmt_pkg::*; #(
	parameter int POOL_NODES = DEF_POOL_NODES,
	parameter int ALPHABET   = DEF_ALPHABET
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic             operation,
	input  logic [SYM_W-1:0] symbol,
	input  logic [IDX_W-1:0] word_index,
	input  logic [LEN_W-1:0] word_length,
	input  logic             last,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [IDX_W-1:0] best_index,
	output logic             found,
	output logic             node_overflow
);

	q_stat_t q_stat;
	logic    push;
	cmd_t    push_data;
	logic    pop;
	cmd_t    pop_data;

	lsmt_front #(.ALPHABET(ALPHABET)) u_front (
		.clk, .arst_n, .item_valid, .item_ready, .operation, .symbol,
		.word_index, .word_length, .last, .q_stat, .push, .push_data
	);

	lsmt_queue u_queue (
		.clk, .arst_n, .push, .push_data, .pop, .q_stat, .pop_data
	);

	lsmt_back #(.POOL_NODES(POOL_NODES), .ALPHABET(ALPHABET)) u_back (
		.clk, .arst_n, .q_stat, .pop_data, .pop, .result_valid, .result_ready,
		.best_index, .found, .node_overflow
	);

endmodule

>>> rtl/lsmt_front.sv
// Front end: takes input transfers and classifies each letter
module lsmt_front import lsmt_pkg::*; #(
	parameter int ALPHABET = DEF_ALPHABET
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic             operation,
	input  logic [SYM_W-1:0] symbol,
	input  logic [IDX_W-1:0] word_index,
	input  logic [LEN_W-1:0] word_length,
	input  logic             last,
	input  q_stat_t          q_stat,
	output logic             push,
	output cmd_t             push_data
);

	logic valid_s1;
	cmd_t cmd_s1;

	assign item_ready = !valid_s1 || !q_stat.full;
	assign push       = valid_s1 && !q_stat.full;
	assign push_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cmd_s1.query  <= (operation == OP_QUERY);
			cmd_s1.sym_ok <= (32'(symbol) < ALPHABET);
			cmd_s1.sym    <= symbol;
			cmd_s1.idx    <= word_index;
			cmd_s1.len    <= word_length;
			cmd_s1.last   <= last;
		end
	end

endmodule

>>> rtl/lsmt_queue.sv
// Two-entry queue between front end and back end
module lsmt_queue import lsmt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_data,
	input  logic    pop,
	output q_stat_t q_stat,
	output cmd_t    pop_data
);

	cmd_t       entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.valid = (cnt_q != 2'd0);
	assign pop_data     = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_data;
	end

endmodule

>>> rtl/lsmt_back.sv
// Back end: trie walk, node memories, result register
module lsmt_back import lsmt_pkg::*; #(
	parameter int POOL_NODES = DEF_POOL_NODES,
	parameter int ALPHABET   = DEF_ALPHABET
) (
	input  logic             clk,
	input  logic             arst_n,
	input  q_stat_t          q_stat,
	input  cmd_t             pop_data,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [IDX_W-1:0] best_index,
	output logic             found,
	output logic             node_overflow
);

	localparam int CHILD_DEPTH = POOL_NODES * ALPHABET;
	localparam int NW          = $clog2(POOL_NODES);
	localparam int AW          = $clog2(CHILD_DEPTH);

	typedef enum logic [1:0] {ST_CLR, ST_IDLE, ST_EX, ST_FIN} state_t;

	logic [NW-1:0] child_mem [CHILD_DEPTH];
	best_t         best_mem  [POOL_NODES];

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [NW-1:0] cur_q;
	logic [NW:0]   used_q;
	logic          stop_q;
	logic          ovf_q;
	cmd_t          cmd_q;
	logic [NW-1:0] child_rd_q;
	best_t         best_rd_q;
	logic          res_valid_q;
	logic [IDX_W-1:0] res_idx_q;
	logic          res_found_q;
	logic          res_ovf_q;

	logic [SYM_W-1:0] sym_sel;
	logic             sym_ok_sel;
	logic [AW-1:0]    child_addr;
	logic             child_we;
	logic [AW-1:0]    child_wa;
	logic [NW-1:0]    child_wd;
	logic             child_re;
	logic             best_we;
	logic [NW-1:0]    best_wa;
	best_t            best_wd;
	logic             best_re;
	logic [NW-1:0]    best_ra;
	logic [NW-1:0]    nxt;
	logic             nstop;
	logic             alloc;
	logic             full_hit;
	logic             out_free;

	assign sym_sel    = (state_q == ST_IDLE) ? pop_data.sym : cmd_q.sym;
	assign sym_ok_sel = (state_q == ST_IDLE) ? pop_data.sym_ok : cmd_q.sym_ok;
	assign child_addr = sym_ok_sel ? AW'(cur_q) * AW'(ALPHABET) + AW'(sym_sel) : '0;
	assign out_free   = !res_valid_q || result_ready;

	// outcome of the walk step for the item in ST_EX
	always_comb begin
		nxt      = cur_q;
		nstop    = stop_q;
		alloc    = 1'b0;
		full_hit = 1'b0;
		if (!stop_q) begin
			if (!cmd_q.sym_ok) begin
				nstop = 1'b1;
			end else if (child_rd_q != '0) begin
				nxt = child_rd_q;
			end else if (cmd_q.query) begin
				nstop = 1'b1;
			end else if (used_q < (NW+1)'(POOL_NODES)) begin
				alloc = 1'b1;
				nxt   = used_q[NW-1:0];
			end else begin
				full_hit = 1'b1;
				nstop    = 1'b1;
			end
		end
	end

	always_comb begin
		pop      = 1'b0;
		child_re = 1'b0;
		child_we = 1'b0;
		child_wa = child_addr;
		child_wd = used_q[NW-1:0];
		best_we  = 1'b0;
		best_wa  = cur_q;
		best_wd  = '{len: cmd_q.len, idx: cmd_q.idx};
		best_re  = 1'b0;
		best_ra  = cur_q;
		unique case (state_q)
			ST_CLR: begin
				child_we = 1'b1;
				child_wa = clr_q;
				child_wd = '0;
				if (32'(clr_q) < POOL_NODES) begin
					best_we = 1'b1;
					best_wa = clr_q[NW-1:0];
					best_wd = '{len: LEN_NONE, idx: '0};
				end
			end
			ST_IDLE: begin
				if (q_stat.valid) begin
					pop      = 1'b1;
					child_re = 1'b1;
					best_re  = 1'b1;
				end
			end
			ST_EX: begin
				if (!cmd_q.query && !stop_q && cmd_q.len < best_rd_q.len) begin
					best_we = 1'b1;
				end
				if (!cmd_q.query && alloc) begin
					child_we = 1'b1;
				end
				if (cmd_q.last && (cmd_q.query || (!stop_q && !nstop))) begin
					best_re = 1'b1;
					best_ra = nxt;
				end
			end
			ST_FIN: begin
				if (!cmd_q.query && cmd_q.len < best_rd_q.len) begin
					best_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_wa] <= child_wd;
		if (child_re) child_rd_q <= child_mem[child_addr];
	end

	always_ff @(posedge clk) begin
		if (best_we) best_mem[best_wa] <= best_wd;
		if (best_re) best_rd_q <= best_mem[best_ra];
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= pop_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			cur_q       <= '0;
			used_q      <= (NW+1)'(1);
			stop_q      <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
			res_ovf_q   <= 1'b0;
		end else begin
			if (res_valid_q && result_ready && !(state_q == ST_FIN && cmd_q.query))
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == CHILD_DEPTH - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_stat.valid) state_q <= ST_EX;
				end
				ST_EX: begin
					if (alloc && !cmd_q.query) used_q <= used_q + (NW+1)'(1);
					if (full_hit) ovf_q <= 1'b1;
					if (cmd_q.last && (cmd_q.query || (!stop_q && !nstop))) begin
						cur_q   <= nxt;
						state_q <= ST_FIN;
					end else if (cmd_q.last) begin
						cur_q   <= '0;
						stop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						cur_q   <= nxt;
						stop_q  <= nstop;
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (!cmd_q.query || out_free) begin
						cur_q   <= '0;
						stop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
					if (cmd_q.query && out_free) begin
						res_valid_q <= 1'b1;
						res_found_q <= (best_rd_q.len != LEN_NONE);
						res_idx_q   <= (best_rd_q.len != LEN_NONE) ? best_rd_q.idx : '0;
						res_ovf_q   <= ovf_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid  = res_valid_q;
	assign best_index    = res_idx_q;
	assign found         = res_found_q;
	assign node_overflow = res_ovf_q;

endmodule

>>> rtl/lsmt_checker.sv
// Port checker for the suffix trie engine, bound to the top level
`include "longest_suffix_match_trie_top_defines.svh"
module lsmt_checker import lsmt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input logic [IDX_W-1:0] best_index,
	input logic             found,
	input logic             node_overflow
);

	`LSMT_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(best_index) && $stable(found) && $stable(node_overflow))
	`LSMT_ASSERT_IMP(a_miss_zero, result_valid && !found, best_index == '0)
	`LSMT_ASSERT_NXT(a_overflow_sticky, node_overflow, node_overflow)

endmodule

bind longest_suffix_match_trie_top lsmt_checker u_chk (.*);

>>> tb/lsmt_checker.sv
// Checker for the suffix trie engine: tracks the trie walk and compares each answer
module lsmt_tb_checker import lsmt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  logic             operation,
	input  logic [SYM_W-1:0] symbol,
	input  logic [IDX_W-1:0] word_index,
	input  logic [LEN_W-1:0] word_length,
	input  logic             last,
	input  logic             result_valid,
	input  logic             result_ready,
	input  logic [IDX_W-1:0] best_index,
	input  logic             found,
	input  logic             node_overflow,
	output int               errors,
	output int               pending
);
	localparam int          NODES     = DEF_POOL_NODES;
	localparam int          LETTERS   = DEF_ALPHABET;
	localparam logic [10:0] WORD_NONE = 11'h7FF;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic             hit;
		logic             ovf;
	} answer_t;

	int               child [NODES*LETTERS];
	logic [LEN_W-1:0] shortest_len [NODES];
	logic [10:0]      shortest_word [NODES];
	int               nodes_taken;
	int               walk_node;
	bit               walk_stopped;
	bit               pool_overflow;
	answer_t          answers [$];

	assign pending = answers.size();

	task automatic keep_shortest(input int node, input logic [LEN_W-1:0] ln,
			input logic [IDX_W-1:0] ix);
		if (ln < shortest_len[node]) begin
			shortest_len[node] = ln;
			shortest_word[node] = {1'b0, ix};
		end
	endtask

	task automatic walk_letter(input logic op, input logic [SYM_W-1:0] s,
			input logic [IDX_W-1:0] ix, input logic [LEN_W-1:0] ln, input logic lst);
		int nxt;
		answer_t a;
		if (op == OP_INSERT) begin
			if (!walk_stopped) begin
				keep_shortest(walk_node, ln, ix);
				if (s < LETTERS) begin
					nxt = child[walk_node*LETTERS + s];
					if (nxt == 0) begin
						if (nodes_taken < NODES) begin
							nxt = nodes_taken;
							nodes_taken++;
							child[walk_node*LETTERS + s] = nxt;
						end else begin
							pool_overflow = 1;
							walk_stopped = 1;
						end
					end
					if (nxt != 0)
						walk_node = nxt;
				end else begin
					walk_stopped = 1;
				end
				if (lst && !walk_stopped)
					keep_shortest(walk_node, ln, ix);
			end
		end else begin
			if (!walk_stopped) begin
				nxt = (s < LETTERS) ? child[walk_node*LETTERS + s] : 0;
				if (nxt != 0)
					walk_node = nxt;
				else
					walk_stopped = 1;
			end
			if (lst) begin
				a.hit = shortest_word[walk_node] != WORD_NONE;
				a.idx = a.hit ? shortest_word[walk_node][IDX_W-1:0] : '0;
				a.ovf = pool_overflow;
				answers.insert(answers.size(), a);
			end
		end
		if (lst) begin
			walk_node = 0;
			walk_stopped = 0;
		end
	endtask

	initial begin
		errors = 0;
		for (int i = 0; i < NODES*LETTERS; i++)
			child[i] = 0;
		for (int i = 0; i < NODES; i++) begin
			shortest_len[i] = LEN_NONE;
			shortest_word[i] = WORD_NONE;
		end
		nodes_taken = 1;
		walk_node = 0;
		walk_stopped = 0;
		pool_overflow = 0;
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (answers.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer idx=%0d found=%0b ovf=%0b",
						$time, best_index, found, node_overflow);
				end else begin
					e = answers.pop_front();
					if (best_index !== e.idx) begin
						errors++;
						$display("%0t: best_index expected %0d actual %0d",
							$time, e.idx, best_index);
					end
					if (found !== e.hit) begin
						errors++;
						$display("%0t: found expected %0b actual %0b", $time, e.hit, found);
					end
					if (node_overflow !== e.ovf) begin
						errors++;
						$display("%0t: node_overflow expected %0b actual %0b",
							$time, e.ovf, node_overflow);
					end
				end
			end
			if (item_valid && item_ready)
				walk_letter(operation, symbol, word_index, word_length, last);
		end
	end
endmodule

>>> tb/testbench.sv
// Testbench top: drives letters and result stalls into the suffix trie engine
module testbench;
	import lsmt_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	logic             operation;
	logic [SYM_W-1:0] symbol;
	logic [IDX_W-1:0] word_index;
	logic [LEN_W-1:0] word_length;
	logic             last;
	logic             result_valid;
	logic             result_ready;
	logic [IDX_W-1:0] best_index;
	logic             found;
	logic             node_overflow;
	int               errors;
	int               pending;
	int               cycles;
	int               burst_left;
	int               sent;
	bit               hold_now;
	logic [SYM_W-1:0] letters [$];
	int               word_start [$];
	int               word_len [$];

	longest_suffix_match_trie_top dut (.*);

	lsmt_tb_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 500000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int mode;
		int cnt;
		mode = 0;
		cnt = 0;
		result_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_now) begin
				hold_now = 0;
				result_ready <= 0;
				repeat (600) @(posedge clk);
			end else begin
				cnt++;
				if (cnt % 50 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
				0: result_ready <= 1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= ($urandom_range(0, 3) == 0);
				default: result_ready <= cnt[2];
				endcase
			end
		end
	end

	task automatic put(input logic op, input logic [SYM_W-1:0] s,
			input logic [IDX_W-1:0] ix, input logic [LEN_W-1:0] ln, input logic lst);
		if (burst_left == 0) begin
			if (item_valid) begin
				item_valid <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		item_valid <= 1;
		operation <= op;
		symbol <= s;
		word_index <= ix;
		word_length <= ln;
		last <= lst;
		do @(posedge clk); while (!item_ready);
		burst_left--;
		sent++;
	endtask

	task automatic insert_word(input int n, input int span, input bit odd_len);
		logic [IDX_W-1:0] ix;
		logic [LEN_W-1:0] ln;
		ix = IDX_W'($urandom_range(0, 1023));
		ln = odd_len ? LEN_W'($urandom_range(1, 127)) : LEN_W'(n);
		word_start.insert(word_start.size(), letters.size());
		word_len.insert(word_len.size(), n);
		for (int i = 0; i < n; i++) begin
			letters.insert(letters.size(), SYM_W'($urandom_range(0, span)));
			put(OP_INSERT, letters[$], ix, ln, i == n-1);
		end
	endtask

	task automatic query_word();
		int k;
		int p;
		int extra;
		logic [SYM_W-1:0] s;
		if (word_len.size() == 0) begin
			put(OP_QUERY, SYM_W'($urandom_range(0, 25)), IDX_W'($urandom), LEN_W'($urandom),
				1'b1);
		end else begin
			k = $urandom_range(0, word_len.size()-1);
			p = $urandom_range(1, word_len[k]);
			extra = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
			for (int i = 0; i < p + extra; i++) begin
				s = (i < p) ? letters[word_start[k]+i] : SYM_W'($urandom_range(0, 25));
				if (i == p-1 && $urandom_range(0, 4) == 0)
					s = SYM_W'($urandom_range(0, 25));
				put(OP_QUERY, s, IDX_W'($urandom), LEN_W'($urandom), i == p + extra - 1);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		item_valid = 0;
		operation = OP_INSERT;
		symbol = '0;
		word_index = '0;
		word_length = '0;
		last = 0;
		burst_left = 0;
		sent = 0;
		hold_now = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// short words, ties, trusted lengths, bad letters, mixed words
		put(OP_INSERT, 5'd0, 10'd5, 7'd1, 1'b1);
		put(OP_INSERT, 5'd0, 10'd1023, 7'd1, 1'b1);
		put(OP_INSERT, 5'd0, 10'd0, 7'd2, 1'b0);
		put(OP_INSERT, 5'd25, 10'd0, 7'd2, 1'b1);
		put(OP_INSERT, 5'd25, 10'd7, 7'd127, 1'b1);
		put(OP_INSERT, 5'd1, 10'd9, 7'd64, 1'b0);
		put(OP_INSERT, 5'd31, 10'd9, 7'd64, 1'b0);
		put(OP_INSERT, 5'd2, 10'd9, 7'd64, 1'b1);
		put(OP_QUERY, 5'd0, 10'd0, 7'd0, 1'b1);
		put(OP_QUERY, 5'd0, 10'd0, 7'd0, 1'b0);
		put(OP_QUERY, 5'd25, 10'd0, 7'd0, 1'b1);
		put(OP_QUERY, 5'd25, 10'd1023, 7'd127, 1'b1);
		put(OP_QUERY, 5'd3, 10'd0, 7'd0, 1'b1);
		put(OP_QUERY, 5'd1, 10'd0, 7'd0, 1'b0);
		put(OP_QUERY, 5'd27, 10'd0, 7'd0, 1'b1);
		put(OP_QUERY, 5'd0, 10'd0, 7'd0, 1'b0);
		put(OP_INSERT, 5'd4, 10'd3, 7'd3, 1'b0);
		put(OP_QUERY, 5'd5, 10'd0, 7'd0, 1'b1);
		put(OP_INSERT, 5'd6, 10'd512, 7'd100, 1'b0);
		put(OP_QUERY, 5'd6, 10'd0, 7'd0, 1'b0);
		put(OP_QUERY, 5'd6, 10'd0, 7'd0, 1'b1);
		item_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		hold_now = 1;
		while (sent < 720) begin
			case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8:
				insert_word(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8), ($urandom_range(0, 1) ? 3 : 25),
					$urandom_range(0, 9) == 0);
			9, 10, 11, 12, 13, 14, 15, 16:
				query_word();
			default:
				repeat ($urandom_range(1, 5))
					put(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 31)),
						IDX_W'($urandom), LEN_W'($urandom), $urandom_range(0, 2) == 0);
			endcase
		end

		// queries over the words seen so far
		repeat (25)
			query_word();
		put(OP_QUERY, 5'd0, 10'd0, 7'd0, 1'b1);
		item_valid <= 0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
